// ===== hw/rtl/yuyv_pkg.sv =====
// yuyv_pkg: shared types and constants for the YUYV to RGB565 framebuffer writer
// no dependencies; used by every module of the block
`default_nettype none

package yuyv_pkg;

  // field widths
  localparam int unsigned LUMA_W   = 8;
  localparam int unsigned CHROMA_W = 8;
  localparam int unsigned PIXEL_W  = 16;
  localparam int unsigned ADDR_W   = 32;
  localparam int unsigned STRIDE_W = 12;
  localparam int unsigned COL_W    = 11;
  localparam int unsigned ROWS_W   = 12;
  localparam int unsigned DELTA_W  = 9;
  localparam int unsigned PROD_W   = 20;
  localparam int unsigned SHIFT    = 10;

  // default row counter width
  localparam int unsigned DIM_BITS_DEF = 12;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_BASE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FB_STRIDE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH_PAIRS = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_ROWS  = 2'd3;

  // register reset values
  localparam logic [ADDR_W-1:0]   FRAME_BASE_RST  = 32'd0;
  localparam logic [STRIDE_W-1:0] FB_STRIDE_RST   = 12'd800;
  localparam logic [COL_W-1:0]    WIDTH_PAIRS_RST = 11'd320;
  localparam logic [ROWS_W-1:0]   FRAME_ROWS_RST  = 12'd480;

  // conversion coefficients, scaled by 1024
  localparam logic signed [PROD_W-1:0] COEF_R_CR = 20'sd1436;
  localparam logic signed [PROD_W-1:0] COEF_G_CB = 20'sd352;
  localparam logic signed [PROD_W-1:0] COEF_G_CR = 20'sd731;
  localparam logic signed [PROD_W-1:0] COEF_B_CB = 20'sd1815;

  // per-pair color offsets shared by both pixel lanes
  typedef struct packed {
    logic signed [DELTA_W-1:0] rd;
    logic signed [DELTA_W-1:0] gd;
    logic signed [DELTA_W-1:0] bd;
  } chroma_delta_t;

  // position info for one pair
  typedef struct packed {
    logic [ADDR_W-1:0] pixel_index;
    logic              eof;
  } addr_info_t;

endpackage

`default_nettype wire

// ===== hw/rtl/yuyv_chroma.sv =====
// yuyv_chroma: chroma offset unit, turns Cb/Cr bytes into R, G and B offsets
// depends on yuyv_pkg
`default_nettype none

module yuyv_chroma (
  input  wire logic [yuyv_pkg::CHROMA_W-1:0] chroma_blue,
  input  wire logic [yuyv_pkg::CHROMA_W-1:0] chroma_red,
  output yuyv_pkg::chroma_delta_t            delta
);

  logic signed [yuyv_pkg::CHROMA_W-1:0] cb;
  logic signed [yuyv_pkg::CHROMA_W-1:0] cr;
  logic signed [yuyv_pkg::PROD_W-1:0]   r_prod;
  logic signed [yuyv_pkg::PROD_W-1:0]   g_prod;
  logic signed [yuyv_pkg::PROD_W-1:0]   b_prod;

  // remove the 128 offset: flipping the top bit gives the two's complement value
  assign cb = signed'(chroma_blue ^ 8'h80);
  assign cr = signed'(chroma_red ^ 8'h80);

  // constant products, then floor shift by 10
  assign r_prod = yuyv_pkg::COEF_R_CR * yuyv_pkg::PROD_W'(cr);
  assign g_prod = yuyv_pkg::COEF_G_CB * yuyv_pkg::PROD_W'(cb)
                + yuyv_pkg::COEF_G_CR * yuyv_pkg::PROD_W'(cr);
  assign b_prod = yuyv_pkg::COEF_B_CB * yuyv_pkg::PROD_W'(cb);

  assign delta.rd = yuyv_pkg::DELTA_W'(r_prod >>> yuyv_pkg::SHIFT);
  assign delta.gd = yuyv_pkg::DELTA_W'(g_prod >>> yuyv_pkg::SHIFT);
  assign delta.bd = yuyv_pkg::DELTA_W'(b_prod >>> yuyv_pkg::SHIFT);

endmodule

`default_nettype wire

// ===== hw/rtl/yuyv_lane.sv =====
// yuyv_lane: one pixel lane, adds the chroma offsets to a luma sample,
// clamps each channel and packs RGB565; depends on yuyv_pkg
`default_nettype none

module yuyv_lane (
  input  wire logic [yuyv_pkg::LUMA_W-1:0]  luma,
  input  wire yuyv_pkg::chroma_delta_t      delta,
  output logic [yuyv_pkg::PIXEL_W-1:0]      pixel
);

  logic signed [10:0] luma_s;
  logic signed [10:0] r_sum;
  logic signed [10:0] g_sum;
  logic signed [10:0] b_sum;
  logic [7:0]         r_byte;
  logic [7:0]         g_byte;
  logic [7:0]         b_byte;

  function automatic logic [7:0] clamp_byte(input logic signed [10:0] v);
    logic [7:0] res;
    if (v < 0) begin
      res = 8'd0;
    end else if (v > 11'sd255) begin
      res = 8'd255;
    end else begin
      res = v[7:0];
    end
    return res;
  endfunction

  // channel sums
  assign luma_s = signed'({3'b000, luma});
  assign r_sum  = luma_s + 11'(delta.rd);
  assign g_sum  = luma_s - 11'(delta.gd);
  assign b_sum  = luma_s + 11'(delta.bd);

  // clamp and pack
  assign r_byte = clamp_byte(r_sum);
  assign g_byte = clamp_byte(g_sum);
  assign b_byte = clamp_byte(b_sum);
  assign pixel  = {r_byte[7:3], g_byte[7:2], b_byte[7:3]};

endmodule

`default_nettype wire

// ===== hw/rtl/yuyv_addr_gen.sv =====
// yuyv_addr_gen: column and row counters and framebuffer pixel index
// depends on yuyv_pkg
`default_nettype none

module yuyv_addr_gen #(
  parameter int unsigned DIM_BITS = yuyv_pkg::DIM_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          step,
  input  wire logic [yuyv_pkg::STRIDE_W-1:0] fb_stride,
  input  wire logic [yuyv_pkg::COL_W-1:0]    width_pairs,
  input  wire logic [yuyv_pkg::ROWS_W-1:0]   frame_rows,
  output yuyv_pkg::addr_info_t               info
);

  logic [yuyv_pkg::COL_W-1:0]             col_r;
  logic [yuyv_pkg::COL_W-1:0]             col_nxt;
  logic [DIM_BITS-1:0]                    row_r;
  logic [DIM_BITS-1:0]                    row_nxt;
  logic [DIM_BITS-1:0]                    rows;
  logic                                   last_col;
  logic                                   last_row;
  logic [DIM_BITS+yuyv_pkg::STRIDE_W-1:0] row_prod;

  // frame height as seen by a row counter of DIM_BITS bits
  assign rows = DIM_BITS'(frame_rows);

  // a counter at or past its limit counts as the last position
  assign last_col = ({1'b0, col_r} + 12'd1) >= {1'b0, width_pairs};
  assign last_row = ({1'b0, row_r} + (DIM_BITS+1)'(1)) >= {1'b0, rows};

  // pixel index of the first pixel of the pair
  assign row_prod = {{yuyv_pkg::STRIDE_W{1'b0}}, row_r} * {{DIM_BITS{1'b0}}, fb_stride};
  assign info.pixel_index = yuyv_pkg::ADDR_W'(row_prod)
                          + yuyv_pkg::ADDR_W'({col_r, 1'b0});
  assign info.eof = last_col && last_row;

  // counter advance
  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (step) begin
      if (last_col) begin
        col_nxt = '0;
        row_nxt = last_row ? '0 : row_r + DIM_BITS'(1);
      end else begin
        col_nxt = col_r + yuyv_pkg::COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/yuyv_to_rgb565_framebuffer_writer.sv =====
// yuyv_to_rgb565_framebuffer_writer: top level, configuration registers,
// pipeline stages and output merge; depends on yuyv_pkg and all yuyv_ modules
`default_nettype none

// Converts one YUYV word (two luma samples, shared Cb/Cr) per transfer into two
// RGB565 pixels plus the framebuffer byte address of the first pixel, with an
// end_of_frame flag on the last pair of the frame. One pair is accepted every
// clock cycle while the output is not stalled; a result passes the stage-one
// registers, then the output register. There are two pipeline stages: the first
// holds the chroma offsets and the pixel index from the row times stride
// product, the second holds the two pixel lanes and the base address add.
// Stages advance independently, so new input is taken into an empty stage one
// while a finished result is still waiting on out_ready. Register writes belong in
// idle periods; after reset the frame counters start at pixel zero.
module yuyv_to_rgb565_framebuffer_writer #(
  parameter int unsigned DIM_BITS = yuyv_pkg::DIM_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // input channel
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [yuyv_pkg::LUMA_W-1:0]     in_luma_first,
  input  wire logic [yuyv_pkg::CHROMA_W-1:0]   in_chroma_blue,
  input  wire logic [yuyv_pkg::LUMA_W-1:0]     in_luma_second,
  input  wire logic [yuyv_pkg::CHROMA_W-1:0]   in_chroma_red,
  // result channel
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic [yuyv_pkg::PIXEL_W-1:0]         out_pixel_first,
  output logic [yuyv_pkg::PIXEL_W-1:0]         out_pixel_second,
  output logic [yuyv_pkg::ADDR_W-1:0]          out_write_address,
  output logic                                 out_end_of_frame,
  // configuration port
  input  wire logic                            cfg_we,
  input  wire logic [yuyv_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [yuyv_pkg::CFG_DATA_W-1:0] cfg_data
);

  logic [yuyv_pkg::ADDR_W-1:0]   frame_base_r;
  logic [yuyv_pkg::STRIDE_W-1:0] fb_stride_r;
  logic [yuyv_pkg::COL_W-1:0]    width_pairs_r;
  logic [yuyv_pkg::ROWS_W-1:0]   frame_rows_r;

  logic                          in_xfer;
  logic                          s1_adv;
  logic                          out_adv;

  yuyv_pkg::chroma_delta_t       delta;
  yuyv_pkg::addr_info_t          addr_info;

  logic                          s1_valid_r;
  logic [yuyv_pkg::LUMA_W-1:0]   s1_luma_first_r;
  logic [yuyv_pkg::LUMA_W-1:0]   s1_luma_second_r;
  yuyv_pkg::chroma_delta_t       s1_delta_r;
  yuyv_pkg::addr_info_t          s1_addr_r;

  logic [yuyv_pkg::PIXEL_W-1:0]  lane_pixel_first;
  logic [yuyv_pkg::PIXEL_W-1:0]  lane_pixel_second;

  logic                          out_valid_r;
  logic [yuyv_pkg::PIXEL_W-1:0]  out_pixel_first_r;
  logic [yuyv_pkg::PIXEL_W-1:0]  out_pixel_second_r;
  logic [yuyv_pkg::ADDR_W-1:0]   out_write_address_r;
  logic                          out_end_of_frame_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_base_r  <= yuyv_pkg::FRAME_BASE_RST;
      fb_stride_r   <= yuyv_pkg::FB_STRIDE_RST;
      width_pairs_r <= yuyv_pkg::WIDTH_PAIRS_RST;
      frame_rows_r  <= yuyv_pkg::FRAME_ROWS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        yuyv_pkg::REG_FRAME_BASE:  frame_base_r  <= cfg_data;
        yuyv_pkg::REG_FB_STRIDE:   fb_stride_r   <= cfg_data[yuyv_pkg::STRIDE_W-1:0];
        yuyv_pkg::REG_WIDTH_PAIRS: width_pairs_r <= cfg_data[yuyv_pkg::COL_W-1:0];
        yuyv_pkg::REG_FRAME_ROWS:  frame_rows_r  <= cfg_data[yuyv_pkg::ROWS_W-1:0];
        default: ;
      endcase
    end
  end

  // pipeline flow control: a stage moves when the one after it has room
  assign out_adv  = !out_valid_r || out_ready;
  assign s1_adv   = !s1_valid_r || out_adv;
  assign in_ready = s1_adv;
  assign in_xfer  = in_valid && in_ready;

  // stage one: chroma offsets and position
  yuyv_chroma u_chroma (
    .chroma_blue (in_chroma_blue),
    .chroma_red  (in_chroma_red),
    .delta       (delta)
  );

  yuyv_addr_gen #(
    .DIM_BITS (DIM_BITS)
  ) u_addr_gen (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (in_xfer),
    .fb_stride   (fb_stride_r),
    .width_pairs (width_pairs_r),
    .frame_rows  (frame_rows_r),
    .info        (addr_info)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_adv) begin
      s1_valid_r <= in_xfer;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_luma_first_r  <= in_luma_first;
      s1_luma_second_r <= in_luma_second;
      s1_delta_r       <= delta;
      s1_addr_r        <= addr_info;
    end
  end

  // stage two: one lane per pixel of the pair
  yuyv_lane u_lane_first (
    .luma  (s1_luma_first_r),
    .delta (s1_delta_r),
    .pixel (lane_pixel_first)
  );

  yuyv_lane u_lane_second (
    .luma  (s1_luma_second_r),
    .delta (s1_delta_r),
    .pixel (lane_pixel_second)
  );

  // merge lanes and address into the output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv && s1_valid_r) begin
      out_pixel_first_r   <= lane_pixel_first;
      out_pixel_second_r  <= lane_pixel_second;
      out_write_address_r <= frame_base_r
                           + {s1_addr_r.pixel_index[yuyv_pkg::ADDR_W-2:0], 1'b0};
      out_end_of_frame_r  <= s1_addr_r.eof;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_pixel_first   = out_pixel_first_r;
  assign out_pixel_second  = out_pixel_second_r;
  assign out_write_address = out_write_address_r;
  assign out_end_of_frame  = out_end_of_frame_r;

`ifndef SYNTH
  // a stalled output with a full first stage must block new input
  assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && out_valid_r && !out_ready |-> !in_ready)
    else $error("input taken while pipeline is full");

  // every input transfer lands in the first stage
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> s1_valid_r)
    else $error("input transfer lost before stage one");

  // output drains when nothing follows it
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_ready && !s1_valid_r |=> !out_valid_r)
    else $error("result repeated after its transfer");
`endif

endmodule

`default_nettype wire

// ===== dv/yuyv_pair_write_checker.sv =====
// yuyv_pair_write_checker: predicts the pixel pair, address and end-of-frame flag for every
// input transfer, then compares each result transfer against the oldest prediction
// depends on yuyv_pkg for port widths, register indexes and register reset values
module yuyv_pair_write_checker #(
  parameter int unsigned DIM_BITS = yuyv_pkg::DIM_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  logic [yuyv_pkg::LUMA_W-1:0]     in_luma_first,
  input  logic [yuyv_pkg::CHROMA_W-1:0]   in_chroma_blue,
  input  logic [yuyv_pkg::LUMA_W-1:0]     in_luma_second,
  input  logic [yuyv_pkg::CHROMA_W-1:0]   in_chroma_red,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  logic [yuyv_pkg::PIXEL_W-1:0]    out_pixel_first,
  input  logic [yuyv_pkg::PIXEL_W-1:0]    out_pixel_second,
  input  logic [yuyv_pkg::ADDR_W-1:0]     out_write_address,
  input  logic                            out_end_of_frame,
  input  logic                            cfg_we,
  input  logic [yuyv_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [yuyv_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                              fail_count,
  output int                              pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ROW_MASK = (1 << DIM_BITS) - 1;

  typedef struct packed {
    logic [yuyv_pkg::PIXEL_W-1:0] pixel_first;
    logic [yuyv_pkg::PIXEL_W-1:0] pixel_second;
    logic [yuyv_pkg::ADDR_W-1:0]  write_address;
    logic                         end_of_frame;
  } pair_write_t;

  // local copy of the registers and the frame position
  logic [yuyv_pkg::ADDR_W-1:0]   frame_base;
  logic [yuyv_pkg::STRIDE_W-1:0] fb_stride;
  logic [yuyv_pkg::COL_W-1:0]    width_pairs;
  logic [yuyv_pkg::ROWS_W-1:0]   frame_rows;
  logic [yuyv_pkg::COL_W-1:0]    pair_column;
  logic [DIM_BITS-1:0]           line_row;

  pair_write_t writes_due[$];
  pair_write_t got_write;
  pair_write_t due_write;
  int          mismatches;

  assign fail_count = mismatches;

  function automatic logic [7:0] clamp_channel(input int v);
    if (v < 0) return 8'd0;
    if (v > 255) return 8'd255;
    return v[7:0];
  endfunction

  function automatic logic [yuyv_pkg::PIXEL_W-1:0] pack_rgb565(input int y, input int rd,
                                                               input int gd, input int bd);
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    r = clamp_channel(y + rd);
    g = clamp_channel(y - gd);
    b = clamp_channel(y + bd);
    return {r[7:3], g[7:2], b[7:3]};
  endfunction

  // color conversion plus placement at the current frame position
  function automatic pair_write_t expected_pair_write(input logic [7:0] y0,
                                                      input logic [7:0] cb_raw,
                                                      input logic [7:0] y1,
                                                      input logic [7:0] cr_raw);
    pair_write_t w;
    int          cb;
    int          cr;
    int          rd;
    int          gd;
    int          bd;
    logic [31:0] pix_idx;
    int unsigned rows_eff;
    cb = int'(cb_raw) - 128;
    cr = int'(cr_raw) - 128;
    // >>> on a signed int floors toward minus infinity
    rd = (1436 * cr) >>> 10;
    gd = (352 * cb + 731 * cr) >>> 10;
    bd = (1815 * cb) >>> 10;
    w.pixel_first  = pack_rgb565(int'(y0), rd, gd, bd);
    w.pixel_second = pack_rgb565(int'(y1), rd, gd, bd);
    pix_idx = 32'(line_row) * 32'(fb_stride) + 32'(pair_column) * 32'd2;
    w.write_address = frame_base + (pix_idx << 1);
    rows_eff = int'(frame_rows) & ROW_MASK;
    w.end_of_frame = ((int'(pair_column) + 1) >= int'(width_pairs)) &&
                     ((int'(line_row) + 1) >= int'(rows_eff));
    return w;
  endfunction

  // column and row counters; a counter at or past a lowered limit counts as last
  function automatic void advance_position();
    int unsigned rows_eff;
    rows_eff = int'(frame_rows) & ROW_MASK;
    if ((int'(pair_column) + 1) >= int'(width_pairs)) begin
      pair_column = '0;
      if ((int'(line_row) + 1) >= int'(rows_eff)) line_row = '0;
      else line_row = line_row + 1'b1;
    end else begin
      pair_column = pair_column + 1'b1;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      frame_base  = yuyv_pkg::FRAME_BASE_RST;
      fb_stride   = yuyv_pkg::FB_STRIDE_RST;
      width_pairs = yuyv_pkg::WIDTH_PAIRS_RST;
      frame_rows  = yuyv_pkg::FRAME_ROWS_RST;
      pair_column = '0;
      line_row    = '0;
      writes_due.delete();
      mismatches  = 0;
      pending    <= 0;
    end else begin
      // register writes, masked to each register's width
      if (cfg_we) begin
        case (cfg_index)
          yuyv_pkg::REG_FRAME_BASE:  frame_base  = cfg_data[yuyv_pkg::ADDR_W-1:0];
          yuyv_pkg::REG_FB_STRIDE:   fb_stride   = cfg_data[yuyv_pkg::STRIDE_W-1:0];
          yuyv_pkg::REG_WIDTH_PAIRS: width_pairs = cfg_data[yuyv_pkg::COL_W-1:0];
          yuyv_pkg::REG_FRAME_ROWS:  frame_rows  = cfg_data[yuyv_pkg::ROWS_W-1:0];
          default: ;
        endcase
      end
      // input transfer: predict, then move the frame position
      if (in_valid && in_ready) begin
        writes_due.push_back(expected_pair_write(in_luma_first, in_chroma_blue,
                                                 in_luma_second, in_chroma_red));
        advance_position();
      end
      // result transfer: compare against the oldest prediction
      if (out_valid && out_ready) begin
        got_write = '{out_pixel_first, out_pixel_second, out_write_address, out_end_of_frame};
        if (writes_due.size() == 0) begin
          $error("result transfer with nothing expected: addr %0h", out_write_address);
          mismatches++;
        end else begin
          due_write = writes_due.pop_front();
          if (got_write.pixel_first !== due_write.pixel_first) begin
            $error("pixel_first: expected %04h, got %04h",
                   due_write.pixel_first, got_write.pixel_first);
            mismatches++;
          end
          if (got_write.pixel_second !== due_write.pixel_second) begin
            $error("pixel_second: expected %04h, got %04h",
                   due_write.pixel_second, got_write.pixel_second);
            mismatches++;
          end
          if (got_write.write_address !== due_write.write_address) begin
            $error("write_address: expected %08h, got %08h",
                   due_write.write_address, got_write.write_address);
            mismatches++;
          end
          if (got_write.end_of_frame !== due_write.end_of_frame) begin
            $error("end_of_frame: expected %0b, got %0b",
                   due_write.end_of_frame, got_write.end_of_frame);
            mismatches++;
          end
        end
      end
      pending <= writes_due.size();
    end
  end

endmodule

// ===== dv/tb_yuyv_to_rgb565_framebuffer_writer.sv =====
// tb_yuyv_to_rgb565_framebuffer_writer: clock, reset, pixel-pair stimulus, register programming,
// output back-pressure and verdict; depends on yuyv_pkg, the block and yuyv_pair_write_checker
module tb_yuyv_to_rgb565_framebuffer_writer;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DIM_BITS     = yuyv_pkg::DIM_BITS_DEF;
  localparam int          RANDOM_PAIRS = 1450;
  localparam int          QUIET_LIMIT  = 4000;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_valid = 1'b0;
  logic                            in_ready;
  logic [yuyv_pkg::LUMA_W-1:0]     in_luma_first = '0;
  logic [yuyv_pkg::CHROMA_W-1:0]   in_chroma_blue = '0;
  logic [yuyv_pkg::LUMA_W-1:0]     in_luma_second = '0;
  logic [yuyv_pkg::CHROMA_W-1:0]   in_chroma_red = '0;
  logic                            out_valid;
  logic                            out_ready = 1'b0;
  logic [yuyv_pkg::PIXEL_W-1:0]    out_pixel_first;
  logic [yuyv_pkg::PIXEL_W-1:0]    out_pixel_second;
  logic [yuyv_pkg::ADDR_W-1:0]     out_write_address;
  logic                            out_end_of_frame;
  logic                            cfg_we = 1'b0;
  logic [yuyv_pkg::CFG_IDX_W-1:0]  cfg_index = yuyv_pkg::REG_FRAME_BASE;
  logic [yuyv_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  int fail_count;
  int pending;

  // stimulus bookkeeping
  int       pairs_sent = 0;
  int       settings_used = 1;
  int       frame_ends = 0;
  int       quiet_cycles = 0;
  bit       gaps_on = 1'b0;
  int       burst_left = 0;
  int       stall_mode = 0;
  int       ready_run = 0;

  yuyv_to_rgb565_framebuffer_writer #(.DIM_BITS(DIM_BITS)) DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_luma_first     (in_luma_first),
    .in_chroma_blue    (in_chroma_blue),
    .in_luma_second    (in_luma_second),
    .in_chroma_red     (in_chroma_red),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_pixel_first   (out_pixel_first),
    .out_pixel_second  (out_pixel_second),
    .out_write_address (out_write_address),
    .out_end_of_frame  (out_end_of_frame),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  yuyv_pair_write_checker #(.DIM_BITS(DIM_BITS)) u_pair_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_luma_first     (in_luma_first),
    .in_chroma_blue    (in_chroma_blue),
    .in_luma_second    (in_luma_second),
    .in_chroma_red     (in_chroma_red),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_pixel_first   (out_pixel_first),
    .out_pixel_second  (out_pixel_second),
    .out_write_address (out_write_address),
    .out_end_of_frame  (out_end_of_frame),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .fail_count        (fail_count),
    .pending           (pending)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // result side back-pressure: always ready, random, or runs of random length
  always @(posedge clk) begin
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 3) != 0);
      default: begin
        if (ready_run == 0) begin
          out_ready <= ~out_ready;
          ready_run = $urandom_range(1, 12);
        end else begin
          ready_run--;
        end
      end
    endcase
  end

  // frame ends seen on accepted results
  always @(posedge clk) begin
    if (out_valid && out_ready && out_end_of_frame) frame_ends++;
  end

  // watchdog on cycles without any transfer or register write
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("yuyv_to_rgb565_framebuffer_writer: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // biased byte: extremes and mid-scale show up often
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0: return 8'd0;
      1: return 8'd255;
      2: return 8'd128;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // one pair transfer, with a random gap first when gaps are on and a burst has run out
  task automatic send_pair(input logic [7:0] y0, input logic [7:0] cb,
                           input logic [7:0] y1, input logic [7:0] cr);
    int gap;
    if (gaps_on && burst_left == 0) begin
      gap = $urandom_range(1, 8);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = $urandom_range(1, 24);
    end
    in_valid       <= 1'b1;
    in_luma_first  <= y0;
    in_chroma_blue <= cb;
    in_luma_second <= y1;
    in_chroma_red  <= cr;
    do @(posedge clk); while (!in_ready);
    pairs_sent++;
    if (burst_left > 0) burst_left--;
  endtask

  task automatic send_random_pairs(input int count);
    repeat (count) send_pair(pick_byte(), pick_byte(), pick_byte(), pick_byte());
  endtask

  // stop sending and wait until every predicted result has been taken
  task automatic wait_drained();
    in_valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [yuyv_pkg::CFG_IDX_W-1:0] idx,
                           input logic [yuyv_pkg::CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
  endtask

  // back-to-back writes of the selected registers; unused upper data bits carry noise
  task automatic program_regs(input logic [3:0] sel, input logic [31:0] base,
                              input logic [31:0] stride, input logic [31:0] width,
                              input logic [31:0] rows);
    if (sel[0]) write_reg(yuyv_pkg::REG_FRAME_BASE, base);
    if (sel[1]) write_reg(yuyv_pkg::REG_FB_STRIDE,
                          (32'($urandom) & ~32'hFFF) | (stride & 32'hFFF));
    if (sel[2]) write_reg(yuyv_pkg::REG_WIDTH_PAIRS,
                          (32'($urandom) & ~32'h7FF) | (width & 32'h7FF));
    if (sel[3]) write_reg(yuyv_pkg::REG_FRAME_ROWS,
                          (32'($urandom) & ~32'hFFF) | (rows & 32'hFFF));
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  initial begin
    logic [3:0]  sel;
    logic [31:0] base;
    logic [31:0] stride;
    logic [31:0] width;
    logic [31:0] rows;
    int          target;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: color extremes under the reset register values
    send_pair(8'd0, 8'd0, 8'd0, 8'd0);
    send_pair(8'd255, 8'd255, 8'd255, 8'd255);
    send_pair(8'd0, 8'd128, 8'd255, 8'd128);
    send_pair(8'd255, 8'd128, 8'd0, 8'd128);
    send_pair(8'd128, 8'd0, 8'd128, 8'd255);
    send_pair(8'd128, 8'd255, 8'd128, 8'd0);
    send_pair(8'd0, 8'd0, 8'd255, 8'd255);
    send_pair(8'd255, 8'd255, 8'd0, 8'd0);
    send_pair(8'd16, 8'd128, 8'd235, 8'd128);
    send_pair(8'd200, 8'd90, 8'd60, 8'd240);
    wait_drained();

    // zero width and zero height: every pair closes the frame, stride of zero
    program_regs(4'b1111, 32'hFFFF_FFFE, 32'd0, 32'd0, 32'd0);
    send_random_pairs(3);
    wait_drained();

    // small frame at the top of the address space so the address wraps
    program_regs(4'b1111, 32'hFFFF_FFF0, 32'd4095, 32'd3, 32'd3);
    send_random_pairs(5);
    wait_drained();

    // lower both limits under a counter that sits past them
    program_regs(4'b1100, 32'd0, 32'd0, 32'd1, 32'd1);
    send_random_pairs(2);
    wait_drained();

    // random phases: new settings, sender gaps and result stalls per phase
    gaps_on    = 1'b1;
    stall_mode <= 1;
    target = pairs_sent + RANDOM_PAIRS;
    while (pairs_sent < target) begin
      if ($urandom_range(0, 3) != 0) begin
        sel = 4'($urandom_range(1, 15));
        case ($urandom_range(0, 5))
          0: base = 32'd0;
          1: base = 32'hFFFF_FFFF;
          2: base = 32'hFFFF_FF00 | 32'($urandom_range(0, 255));
          default: base = $urandom;
        endcase
        case ($urandom_range(0, 5))
          0: stride = 32'd0;
          1: stride = 32'd1;
          2: stride = 32'd4095;
          default: stride = $urandom_range(1, 4095);
        endcase
        case ($urandom_range(0, 7))
          0: width = 32'd0;
          1: width = 32'd1;
          2: width = 32'd2047;
          default: width = $urandom_range(1, 6);
        endcase
        case ($urandom_range(0, 7))
          0: rows = 32'd0;
          1: rows = 32'd1;
          2: rows = 32'd4095;
          default: rows = $urandom_range(1, 5);
        endcase
        program_regs(sel, base, stride, width, rows);
      end
      gaps_on    = ($urandom_range(0, 2) != 0);
      burst_left = 0;
      stall_mode <= $urandom_range(0, 2);
      send_random_pairs($urandom_range(8, 80));
      wait_drained();
    end

    repeat (10) @(posedge clk);
    if (pending != 0) $error("%0d results never arrived", pending);
    $display("%0d pairs converted under %0d register settings, %0d frame ends seen",
             pairs_sent, settings_used, frame_ends);
    if (fail_count == 0 && pending == 0) begin
      $display("yuyv_to_rgb565_framebuffer_writer: match");
    end else begin
      $display("yuyv_to_rgb565_framebuffer_writer: mismatch");
    end
    $finish;
  end

endmodule
